// ===== src/err_pkg.sv =====
`default_nettype none

package err_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DEF_MAX_DOCS = 1024;
    localparam int GRADE_W = 4;
    localparam logic [GRADE_W-1:0] MAX_GRADE_RESET = GRADE_W'(4);
    localparam logic [FRAC_BITS:0] ONE_VAL = (FRAC_BITS+1)'(1) << FRAC_BITS;

    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE = 3'd0;
    localparam step_t ST_PROB = 3'd1;
    localparam step_t ST_MUL  = 3'd2;
    localparam step_t ST_UPD  = 3'd3;
    localparam step_t ST_DIV  = 3'd4;
    localparam step_t ST_ACC  = 3'd5;
    localparam step_t ST_OUT  = 3'd6;
    localparam step_t ST_LAST = ST_OUT;

    typedef enum logic [2:0] {
        J_NEXT,
        J_NO_IN,
        J_DIV_BUSY,
        J_NOT_LAST,
        J_OUT_BUSY
    } jump_t;

    typedef struct packed {
        logic  accept;
        logic  ld_prob;
        logic  ld_mul;
        logic  ld_upd;
        logic  div_step;
        logic  ld_acc;
        logic  ld_out;
        jump_t jump;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    function automatic ctrl_word_t prog_rom(input step_t pc);
        ctrl_word_t w;
        w = '{accept: 1'b0, ld_prob: 1'b0, ld_mul: 1'b0, ld_upd: 1'b0, div_step: 1'b0,
              ld_acc: 1'b0, ld_out: 1'b0, jump: J_NEXT, target: ST_IDLE};
        case (pc)
            ST_IDLE:
            begin
                w.accept = 1'b1;
                w.jump   = J_NO_IN;
                w.target = ST_IDLE;
            end
            ST_PROB: w.ld_prob = 1'b1;
            ST_MUL:  w.ld_mul = 1'b1;
            ST_UPD:  w.ld_upd = 1'b1;
            ST_DIV:
            begin
                w.div_step = 1'b1;
                w.jump     = J_DIV_BUSY;
                w.target   = ST_DIV;
            end
            ST_ACC:
            begin
                w.ld_acc = 1'b1;
                w.jump   = J_NOT_LAST;
                w.target = ST_IDLE;
            end
            ST_OUT:
            begin
                w.ld_out = 1'b1;
                w.jump   = J_OUT_BUSY;
                w.target = ST_OUT;
            end
            default:
            begin
                w.jump   = J_NEXT;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/err_div.sv =====
`default_nettype none

module err_div
    import err_pkg::*;
#(
    parameter int FW = FRAC_BITS,
    parameter int PW = 11
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire div_ctl_t      ctl,
    input  wire logic [FW-1:0] dividend,
    input  wire logic [PW-1:0] divisor,
    output logic      [FW-1:0] quotient,
    output logic               busy
);

    localparam int CW = (FW > 1) ? $clog2(FW) : 1;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [PW-1:0] rem_reg;
    logic [PW-1:0] rem_next;
    logic [FW-1:0] quo_reg;
    logic [FW-1:0] quo_next;
    logic [PW-1:0] div_reg;
    logic [PW-1:0] div_next;
    logic [PW:0]   trial;
    logic [PW:0]   diff;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        trial    = {rem_reg, quo_reg[FW-1]};
        diff     = trial - {1'b0, div_reg};
        if (ctl.load)
        begin
            cnt_next = CW'(FW - 1);
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
        end
        else if (ctl.step)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[PW-1:0];
                quo_next = {quo_reg[FW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PW-1:0];
                quo_next = {quo_reg[FW-2:0], 1'b0};
            end
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient = quo_reg;
    assign busy     = (cnt_reg != '0);

endmodule

`default_nettype wire

// ===== src/expected_reciprocal_rank_unit.sv =====
// Each item passes through the steps PROB, MUL, UPD, DIV and ACC after it is accepted in IDLE;
// the serial divider works through DIV. A new item is taken only once the last is through ACC.
// A list's final item also passes through OUT, and waits there while the output register stays full.
// Reset clears the list state, sets max_grade to 4 and leaves the output empty.
`default_nettype none

module expected_reciprocal_rank_unit
    import err_pkg::*;
#(
    parameter int MAX_DOCS = DEF_MAX_DOCS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [GRADE_W-1:0]   max_grade,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [GRADE_W-1:0]   grade,
    input  wire logic                 last_doc,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [FRAC_BITS:0]   rank_score
);

    localparam int F  = FRAC_BITS;
    localparam int PW = $clog2(MAX_DOCS + 1);

    step_t                pc_reg;
    step_t                pc_next;
    ctrl_word_t           cw;
    logic                 take_jump;
    logic                 out_free;
    logic                 accept;

    logic [GRADE_W-1:0]   mg_reg;
    logic [GRADE_W-1:0]   g_reg;
    logic [GRADE_W-1:0]   g_sat;
    logic                 last_reg;
    logic [F-1:0]         r_reg;
    logic [2*F:0]         mul_reg;
    logic [F:0]           prod_reg;
    logic [F:0]           prod_next;
    logic [F:0]           sum_reg;
    logic [F:0]           sum_next;
    logic [F+1:0]         sum_wide;
    logic [PW-1:0]        pos_reg;
    logic [PW-1:0]        pos_next;
    logic                 out_valid_reg;
    logic [F:0]           out_reg;
    logic [14:0]          ones;
    logic [F+14:0]        r_wide;

    div_ctl_t             div_ctl;
    logic [F-1:0]         quotient;
    logic                 div_busy;

    err_div #(
        .FW (F),
        .PW (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (mul_reg[2*F-1:F]),
        .divisor  (pos_reg),
        .quotient (quotient),
        .busy     (div_busy)
    );

    always_comb
    begin
        cw       = prog_rom(pc_reg);
        out_free = !out_valid_reg || !out_stall;
        accept   = cw.accept && in_valid;
        case (cw.jump)
            J_NO_IN:    take_jump = !in_valid;
            J_DIV_BUSY: take_jump = div_busy;
            J_NOT_LAST: take_jump = !last_reg;
            J_OUT_BUSY: take_jump = !out_free;
            default:    take_jump = 1'b0;
        endcase
        if (take_jump)
        begin
            pc_next = cw.target;
        end
        else if (pc_reg == ST_LAST)
        begin
            pc_next = ST_IDLE;
        end
        else
        begin
            pc_next = pc_reg + 3'd1;
        end
        div_ctl.load = cw.ld_upd;
        div_ctl.step = cw.div_step;

        g_sat  = (grade > mg_reg) ? mg_reg : grade;
        ones   = (15'(1) << g_reg) - 15'(1);
        r_wide = ((F+15)'(ones) << F) >> mg_reg;

        prod_next = prod_reg - {1'b0, mul_reg[2*F-1:F]} - (F+1)'(|mul_reg[F-1:0]);
        sum_wide  = (F+2)'(sum_reg) + (F+2)'(quotient);
        sum_next  = (sum_wide > (F+2)'(ONE_VAL)) ? ONE_VAL : sum_wide[F:0];
        pos_next  = (pos_reg < PW'(MAX_DOCS)) ? pos_reg + PW'(1) : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_IDLE;
            mg_reg        <= MAX_GRADE_RESET;
            prod_reg      <= ONE_VAL;
            sum_reg       <= '0;
            pos_reg       <= PW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg_valid)
            begin
                mg_reg <= max_grade;
            end
            if (cw.ld_upd)
            begin
                prod_reg <= prod_next;
            end
            if (cw.ld_acc)
            begin
                sum_reg <= sum_next;
                pos_reg <= pos_next;
            end
            if (cw.ld_out && out_free)
            begin
                out_valid_reg <= 1'b1;
                prod_reg      <= ONE_VAL;
                sum_reg       <= '0;
                pos_reg       <= PW'(1);
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            g_reg    <= g_sat;
            last_reg <= last_doc;
        end
        if (cw.ld_prob)
        begin
            r_reg <= r_wide[F-1:0];
        end
        if (cw.ld_mul)
        begin
            mul_reg <= (2*F+1)'(r_reg) * (2*F+1)'(prod_reg);
        end
        if (cw.ld_out && out_free)
        begin
            out_reg <= sum_reg;
        end
    end

    assign cfg_ready  = 1'b1;
    assign in_stall   = !cw.accept;
    assign out_valid  = out_valid_reg;
    assign rank_score = out_reg;

`ifndef SYNTHESIS
    a_out_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_score_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg <= ONE_VAL))
        else $error("score above one");

    a_prod_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        prod_reg <= ONE_VAL)
        else $error("continue product above one");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) && (pos_reg <= PW'(MAX_DOCS)))
        else $error("rank position out of range");
`endif

endmodule

`default_nettype wire
